@@ src/rwrs_pkg.sv @@
// Shared types and constants for the robust window reversion score block.
// No dependencies; imported by every module of the block.
`default_nettype none
package rwrs_pkg;

  localparam int unsigned MaxWin = 40;
  localparam int unsigned MinWin = 5;
  localparam int unsigned IdxW   = 6;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [16:0] MAD_K_Q16 = 17'd97164;
  localparam logic [49:0] SCALE_EPS = 50'd4398047;
  localparam logic signed [63:0] DEN_EPS = 64'sd4503;
  localparam logic [23:0] SCORE_MAX = 24'd327680;
  localparam logic [22:0] DEV_MAX   = 23'h7FFFFF;
  localparam logic signed [34:0] RET_SAT_P = 35'sd268435456;
  localparam logic signed [34:0] RET_SAT_N = -35'sd268435456;
  localparam logic [16:0] GATE_ONE  = 17'd65536;

  localparam logic [5:0]  WIN_RST = 6'd20;
  localparam logic [18:0] THR_RST = 19'd131072;

  // configuration register indexes
  localparam logic CFG_WIN = 1'b0;
  localparam logic CFG_THR = 1'b1;

  typedef struct packed {
    logic [5:0]  win;
    logic [18:0] thr;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/rwrs_log.sv @@
// Front end: accepts prices and converts each to a natural log in Q6.26.
// Uses rwrs_pkg; one squaring multiplier shared over the fraction bits.
`default_nettype none
module rwrs_log (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [31:0] price_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  output logic [31:0] lp_o,
  output logic        lp_valid_o,
  input  wire         lp_ready_i
);
  import rwrs_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_NORM = 3'd1;
  localparam logic [2:0] F_SQ   = 3'd2;
  localparam logic [2:0] F_LN   = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [31:0] m_q, m_d;
  logic [4:0]  e_q, e_d;
  logic [25:0] frac_q, frac_d;
  logic [4:0]  i_q, i_d;
  logic [31:0] lp_q, lp_d;

  logic [63:0] sq;
  logic [32:0] t;
  logic [5:0]  ex;
  logic signed [32:0] l2;
  logic [32:0] mag;
  logic [63:0] prod;
  logic [31:0] r;

  always_comb begin
    sq   = {32'd0, m_q} * {32'd0, m_q};
    t    = sq[63:31];
    ex   = {1'b0, e_q} - 6'd8;
    l2   = {ex[5], ex, frac_q};
    mag  = l2[32] ? 33'(-l2) : 33'(l2);
    prod = {32'd0, mag[31:0]} * {32'd0, LN2_Q32} + 64'h8000_0000;
    r    = prod[63:32];
  end

  always_comb begin
    st_d   = st_q;
    m_d    = m_q;
    e_d    = e_q;
    frac_d = frac_q;
    i_d    = i_q;
    lp_d   = lp_q;
    case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          m_d  = (price_i == 32'd0) ? 32'd1 : price_i;
          e_d  = 5'd31;
          st_d = F_NORM;
        end
      end
      F_NORM: begin
        if (m_q[31]) begin
          i_d    = 5'd0;
          frac_d = 26'd0;
          st_d   = F_SQ;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          e_d = e_q - 5'd1;
        end
      end
      F_SQ: begin
        if (t[32]) begin
          frac_d = {frac_q[24:0], 1'b1};
          m_d    = t[32:1];
        end else begin
          frac_d = {frac_q[24:0], 1'b0};
          m_d    = t[31:0];
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'd25) st_d = F_LN;
      end
      F_LN: begin
        lp_d = l2[32] ? (32'd0 - r) : r;
        st_d = F_PUSH;
      end
      F_PUSH: begin
        if (lp_ready_i) st_d = F_IDLE;
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    e_q    <= e_d;
    frac_q <= frac_d;
    i_q    <= i_d;
    lp_q   <= lp_d;
  end

  assign in_ready_o = (st_q == F_IDLE);
  assign lp_valid_o = (st_q == F_PUSH);
  assign lp_o       = lp_q;

endmodule
`default_nettype wire

@@ src/rwrs_queue.sv @@
// Two-entry queue of log prices between the log front end and the evaluator.
// Uses rwrs_pkg only for house consistency of types.
`default_nettype none
module rwrs_queue (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [31:0] wdata_i,
  input  wire         wvalid_i,
  output logic        wready_o,
  output logic [31:0] rdata_o,
  output logic        rvalid_o,
  input  wire         rready_i
);
  import rwrs_pkg::*;

  logic [31:0] ent_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign wready_o = (cnt_q != 2'd2);
  assign rvalid_o = (cnt_q != 2'd0);
  assign rdata_o  = ent_q[rp_q];
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= wdata_i;
  end

endmodule
`default_nettype wire

@@ src/rwrs_eval.sv @@
// Back end: log-price ring, median/MAD rank search, robust z, return
// autocorrelation, gate and score, result register. Uses rwrs_pkg.
`default_nettype none
module rwrs_eval (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rwrs_pkg::cfg_t      cfg_i,
  input  wire  [31:0]         lp_i,
  input  wire                 lp_valid_i,
  output logic                lp_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_wf_o,
  output logic [18:0]         out_score_o,
  output logic [23:0]         out_dev_o,
  output logic                out_sig_o
);
  import rwrs_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_CAND  = 4'd1;
  localparam logic [3:0] B_CANDW = 4'd2;
  localparam logic [3:0] B_SCAN  = 4'd3;
  localparam logic [3:0] B_SCALE = 4'd4;
  localparam logic [3:0] B_CHK   = 4'd5;
  localparam logic [3:0] B_ZDIV  = 4'd6;
  localparam logic [3:0] B_RET   = 4'd7;
  localparam logic [3:0] B_CORR  = 4'd8;
  localparam logic [3:0] B_GATE  = 4'd9;
  localparam logic [3:0] B_GDIV  = 4'd10;
  localparam logic [3:0] B_SCORE = 4'd11;
  localparam logic [3:0] B_DONE  = 4'd12;

  localparam logic [1:0] PH_LP  = 2'd0;
  localparam logic [1:0] PH_AD  = 2'd1;
  localparam logic [1:0] PH_RET = 2'd2;

  localparam logic [5:0] WIN_MAX = 6'(MaxWin);
  localparam logic [5:0] WIN_MIN = 6'(MinWin);

  logic [31:0] ring_mem [MaxWin];
  logic [32:0] ret_mem  [MaxWin];
  logic [31:0] ring_rd_q;
  logic [32:0] ret_rd_q;

  logic [3:0]  st_q;
  logic [1:0]  ph_q;
  logic [5:0]  wp_q, fill_q, n_q, base_q, ci_q, sj_q, lt_q, le_q;
  logic        pend_q, pv_q, neg_q, ov_q;
  logic signed [33:0] cand_q, med_q, mad_q, medr_q;
  logic [31:0] newest_q;
  logic [49:0] scale_q;
  logic [74:0] zrem_q, zdsh_q;
  logic [23:0] zq_q;
  logic [4:0]  kcnt_q;
  logic signed [32:0] prev_q;
  logic signed [29:0] cprev_q;
  logic signed [59:0] pnum_q, pden_q;
  logic signed [63:0] num_q, den_q;
  logic [63:0] grem_q;
  logic [15:0] gq_q;
  logic [16:0] gate_q;
  logic        res_wf_q, res_sig_q;
  logic [18:0] res_score_q;
  logic [23:0] res_dev_q;
  logic        o_wf_q, o_sig_q;
  logic [18:0] o_score_q;
  logic [23:0] o_dev_q;

  logic [5:0]  n_cl, fill_nx, wp_nx, idx_sel, ring_addr, ret_addr, cnt_w, kmid, base_nx;
  logic [6:0]  rsum, bsum;
  logic signed [33:0] ring_val, ad_val, val_w, diff;
  logic [32:0] mag;
  logic signed [34:0] cfull;
  logic signed [29:0] csat;
  logic [63:0] grem2;
  logic        zge, gge, found;
  logic [22:0] zabs;
  logic [39:0] sprod;
  logic [23:0] sc;
  logic [18:0] score_w;
  logic        out_load;

  always_comb begin
    if (cfg_i.win < WIN_MIN) n_cl = WIN_MIN;
    else if (cfg_i.win > WIN_MAX) n_cl = WIN_MAX;
    else n_cl = cfg_i.win;
    fill_nx = (fill_q == WIN_MAX) ? WIN_MAX : fill_q + 6'd1;
    wp_nx   = (wp_q == WIN_MAX - 6'd1) ? 6'd0 : wp_q + 6'd1;
    bsum    = {1'b0, wp_nx} + ({1'b0, WIN_MAX} - {1'b0, n_cl});
    base_nx = (bsum >= {1'b0, WIN_MAX}) ? 6'(bsum - {1'b0, WIN_MAX}) : bsum[5:0];
    idx_sel = (st_q == B_CAND) ? ci_q : sj_q;
    rsum    = {1'b0, base_q} + {1'b0, idx_sel};
    ring_addr = (rsum >= {1'b0, WIN_MAX}) ? 6'(rsum - {1'b0, WIN_MAX}) : rsum[5:0];
    ret_addr  = (idx_sel < WIN_MAX) ? idx_sel : 6'd0;
    cnt_w   = (ph_q == PH_RET) ? n_q - 6'd1 : n_q;
    kmid    = {1'b0, cnt_w[5:1]};
    ring_val = {{2{ring_rd_q[31]}}, ring_rd_q};
    ad_val   = ring_val - med_q;
    if (ad_val < 0) ad_val = -ad_val;
    case (ph_q)
      PH_LP:   val_w = ring_val;
      PH_AD:   val_w = ad_val;
      PH_RET:  val_w = {ret_rd_q[32], ret_rd_q};
      default: val_w = ring_val;
    endcase
    found = (lt_q <= kmid) && (kmid < le_q);
    diff  = {{2{newest_q[31]}}, newest_q} - med_q;
    mag   = (diff < 0) ? 33'(-diff) : 33'(diff);
    zge   = (zrem_q >= zdsh_q);
    cfull = {{2{ret_rd_q[32]}}, ret_rd_q} - {medr_q[33], medr_q};
    if (cfull > RET_SAT_P) csat = 30'(RET_SAT_P);
    else if (cfull < RET_SAT_N) csat = 30'(RET_SAT_N);
    else csat = 30'(cfull);
    grem2 = {grem_q[62:0], 1'b0};
    gge   = (grem2 >= 64'(den_q));
    zabs  = zq_q[23] ? DEV_MAX : zq_q[22:0];
    sprod = {17'd0, zabs} * {23'd0, gate_q};
    sc    = sprod[39:16];
    score_w = (sc > SCORE_MAX) ? 19'(SCORE_MAX) : sc[18:0];
  end

  assign out_load = (st_q == B_DONE) && (!ov_q || out_ready_i);

  // ring and return memories, registered reads
  always_ff @(posedge clk_i) begin
    if (st_q == B_IDLE && lp_valid_i) ring_mem[wp_q] <= lp_i;
    if (st_q == B_RET && pend_q && sj_q >= 6'd2)
      ret_mem[sj_q - 6'd2] <= 33'({ring_rd_q[31], ring_rd_q} - prev_q);
    ring_rd_q <= ring_mem[ring_addr];
    ret_rd_q  <= ret_mem[ret_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      ph_q   <= PH_LP;
      wp_q   <= 6'd0;
      fill_q <= 6'd0;
      ov_q   <= 1'b0;
    end else begin
      if (out_load) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (lp_valid_i) begin
            wp_q     <= wp_nx;
            fill_q   <= fill_nx;
            n_q      <= n_cl;
            base_q   <= base_nx;
            newest_q <= lp_i;
            ph_q     <= PH_LP;
            ci_q     <= 6'd0;
            if (fill_nx < n_cl) begin
              res_wf_q    <= 1'b0;
              res_score_q <= 19'd0;
              res_dev_q   <= 24'd0;
              res_sig_q   <= 1'b0;
              st_q        <= B_DONE;
            end else begin
              st_q <= B_CAND;
            end
          end
        end
        B_CAND: st_q <= B_CANDW;
        B_CANDW: begin
          cand_q <= val_w;
          sj_q   <= 6'd0;
          pend_q <= 1'b0;
          lt_q   <= 6'd0;
          le_q   <= 6'd0;
          st_q   <= B_SCAN;
        end
        B_SCAN: begin
          if (pend_q) begin
            if (val_w < cand_q) lt_q <= lt_q + 6'd1;
            if (val_w <= cand_q) le_q <= le_q + 6'd1;
          end
          pend_q <= (sj_q < cnt_w);
          if (sj_q < cnt_w) sj_q <= sj_q + 6'd1;
          if (sj_q == cnt_w && !pend_q) begin
            if (!found) begin
              ci_q <= ci_q + 6'd1;
              st_q <= B_CAND;
            end else begin
              ci_q <= 6'd0;
              case (ph_q)
                PH_LP: begin
                  med_q <= cand_q;
                  ph_q  <= PH_AD;
                  st_q  <= B_CAND;
                end
                PH_AD: begin
                  mad_q <= cand_q;
                  st_q  <= B_SCALE;
                end
                default: begin
                  // pend_q is already cleared by the scan above
                  medr_q <= cand_q;
                  sj_q   <= 6'd0;
                  pv_q   <= 1'b0;
                  num_q  <= 64'sd0;
                  den_q  <= 64'sd0;
                  st_q   <= B_CORR;
                end
              endcase
            end
          end
        end
        B_SCALE: begin
          scale_q <= 50'(mad_q[32:0]) * 50'(MAD_K_Q16);
          st_q    <= B_CHK;
        end
        B_CHK: begin
          if (scale_q < SCALE_EPS) begin
            res_wf_q    <= 1'b1;
            res_score_q <= 19'd0;
            res_dev_q   <= 24'd0;
            res_sig_q   <= 1'b0;
            st_q        <= B_DONE;
          end else begin
            zrem_q <= {10'd0, mag, 32'd0};
            zdsh_q <= {2'd0, scale_q, 23'd0};
            neg_q  <= (diff < 0);
            kcnt_q <= 5'd23;
            st_q   <= B_ZDIV;
          end
        end
        B_ZDIV: begin
          if (zge) zrem_q <= zrem_q - zdsh_q;
          zq_q   <= {zq_q[22:0], zge};
          zdsh_q <= {1'b0, zdsh_q[74:1]};
          kcnt_q <= kcnt_q - 5'd1;
          if (kcnt_q == 5'd0) begin
            sj_q   <= 6'd0;
            pend_q <= 1'b0;
            st_q   <= B_RET;
          end
        end
        B_RET: begin
          if (pend_q) prev_q <= {ring_rd_q[31], ring_rd_q};
          pend_q <= (sj_q < n_q);
          if (sj_q < n_q) sj_q <= sj_q + 6'd1;
          if (sj_q == n_q && !pend_q) begin
            ph_q <= PH_RET;
            ci_q <= 6'd0;
            st_q <= B_CAND;
          end
        end
        B_CORR: begin
          if (pend_q) begin
            cprev_q <= csat;
            if (sj_q >= 6'd2) begin
              pnum_q <= 60'(csat) * 60'(cprev_q);
              pden_q <= 60'(cprev_q) * 60'(cprev_q);
              pv_q   <= 1'b1;
            end else begin
              pv_q <= 1'b0;
            end
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q) begin
            num_q <= num_q + 64'(pnum_q);
            den_q <= den_q + 64'(pden_q);
          end
          pend_q <= (sj_q < cnt_w);
          if (sj_q < cnt_w) sj_q <= sj_q + 6'd1;
          if (sj_q == cnt_w && !pend_q && !pv_q) st_q <= B_GATE;
        end
        B_GATE: begin
          if (den_q <= DEN_EPS || num_q <= 64'sd0) begin
            gate_q <= GATE_ONE;
            st_q   <= B_SCORE;
          end else if (num_q >= den_q) begin
            gate_q <= 17'd0;
            st_q   <= B_SCORE;
          end else begin
            grem_q <= 64'(num_q);
            gq_q   <= 16'd0;
            kcnt_q <= 5'd15;
            st_q   <= B_GDIV;
          end
        end
        B_GDIV: begin
          grem_q <= gge ? grem2 - 64'(den_q) : grem2;
          gq_q   <= {gq_q[14:0], gge};
          kcnt_q <= kcnt_q - 5'd1;
          if (kcnt_q == 5'd0) begin
            gate_q <= GATE_ONE - {1'b0, gq_q[14:0], gge};
            st_q   <= B_SCORE;
          end
        end
        B_SCORE: begin
          res_wf_q    <= 1'b1;
          res_score_q <= score_w;
          res_dev_q   <= neg_q ? (24'd0 - {1'b0, zabs}) : {1'b0, zabs};
          res_sig_q   <= (score_w > cfg_i.thr);
          st_q        <= B_DONE;
        end
        B_DONE: begin
          if (out_load) begin
            o_wf_q    <= res_wf_q;
            o_score_q <= res_score_q;
            o_dev_q   <= res_dev_q;
            o_sig_q   <= res_sig_q;
            st_q      <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  assign lp_ready_o  = (st_q == B_IDLE);
  assign out_valid_o = ov_q;
  assign out_wf_o    = o_wf_q;
  assign out_score_o = o_score_q;
  assign out_dev_o   = o_dev_q;
  assign out_sig_o   = o_sig_q;

endmodule
`default_nettype wire

@@ src/robust_window_reversion_score_core.sv @@
// Robust window reversion score: price stream in, one score result per price.
// Top level; uses rwrs_pkg, rwrs_log, rwrs_queue and rwrs_eval.
//
// Input stream: one Q24.8 price per transfer on s_axis_*.
// Output stream: one result per price on m_axis_*: window-full flag, Q3.16
// score, signed Q7.16 robust z and signal flag.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 = window size, 1 = signal threshold on the score); write only while idle.
// Front: log conversion normalises each price, then does one squaring
// per fraction bit; a two-entry queue lets it run ahead of the evaluator.
// Back: a warm-up item goes from idle straight to the result state. The
// time for a full window of n is set by the rank search for the three
// medians, one ring or return memory read per cycle, plus a 24-bit z
// division and a 16-bit gate division.
// Reset clears pointers, fill count and handshakes; config returns to
// window 20, threshold 2.0. A stalled receiver holds the result register;
// the evaluator then waits with its next result, and the front end keeps
// accepting until the queue is full.
`default_nettype none
module robust_window_reversion_score_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] price_in
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [0] window_full, [19:1] score,
                                      // [43:20] robust_z, [44] signal
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [18:0] cfg_wdata_i
);
  import rwrs_pkg::*;

  cfg_t        cfg_q;
  logic [31:0] f_lp, q_lp;
  logic        f_valid, f_ready, q_valid, q_ready;
  logic        wf, sig;
  logic [18:0] score;
  logic [23:0] dev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win <= WIN_RST;
      cfg_q.thr <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIN: cfg_q.win <= cfg_wdata_i[5:0];
        CFG_THR: cfg_q.thr <= cfg_wdata_i;
        default: cfg_q.thr <= cfg_q.thr;
      endcase
    end
  end

  rwrs_log u_log (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .price_i    (s_axis_tdata),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .lp_o       (f_lp),
    .lp_valid_o (f_valid),
    .lp_ready_i (f_ready)
  );

  rwrs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wdata_i  (f_lp),
    .wvalid_i (f_valid),
    .wready_o (f_ready),
    .rdata_o  (q_lp),
    .rvalid_o (q_valid),
    .rready_i (q_ready)
  );

  rwrs_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .lp_i        (q_lp),
    .lp_valid_i  (q_valid),
    .lp_ready_o  (q_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_wf_o    (wf),
    .out_score_o (score),
    .out_dev_o   (dev),
    .out_sig_o   (sig)
  );

  assign m_axis_tdata = {3'd0, sig, dev, score, wf};

`ifndef SYNTH
  a_cold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[44:1] == 44'd0)
    else $error("result before window full is not zero");
  a_dev_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[43:20] == 24'd0 |-> m_axis_tdata[19:1] == 19'd0)
    else $error("score without deviation");
  a_sig_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tdata[19:1] != 19'd0)
    else $error("signal with zero score");
`endif

endmodule
`default_nettype wire
